// ===== rtl/core/olid_pkg.sv =====
package olid_pkg;

   // Field widths of the two channels
   localparam int DATA_W      = 32;
   localparam int POS_W       = 4;
   localparam int COUNT_W     = 5;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_FIELD_W = CMD_W + POS_W + DATA_W;
   localparam int RSP_FIELD_W = STATUS_W + COUNT_W + 1 + 1 + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_SHIFT0,
      S_SHIFT,
      S_DRAIN,
      S_INS_WR,
      S_FINISH
   } state_type;

   typedef enum logic {
      RD_POS,
      RD_SRC
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_APPEND,
      WR_SHIFT,
      WR_INSERT
   } wr_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       capture;
      logic       stat_load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       src_load;
      logic       src_step;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_load;
   } ctrl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      cmd_type    op;
      status_type err;
      logic       del_last;
      logic       at_end;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/olid_datapath.sv =====
module olid_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  olid_pkg::ctrl_type          ctrl,
   output olid_pkg::dp_status_type     stat,
   input  olid_pkg::cmd_type           req_command,
   input  logic [olid_pkg::POS_W-1:0]  req_position,
   input  logic signed [olid_pkg::DATA_W-1:0] req_item,
   input  logic                        rsp_tready,
   output logic                        rsp_valid,
   output olid_pkg::status_type        rsp_status,
   output logic [olid_pkg::COUNT_W-1:0] rsp_count,
   output logic                        rsp_empty_flag,
   output logic                        rsp_full_flag,
   output logic signed [olid_pkg::DATA_W-1:0] rsp_read_value
);
   import olid_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Entry storage
   logic signed [DATA_W-1:0] entry_mem [DEPTH];

   // Captured transaction
   cmd_type                  op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] item_ff;

   // Working registers
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]            src_ff, src_in;
   logic [AW-1:0]            wdst_ff, wdst_in;
   logic signed [DATA_W-1:0] rdata_ff;
   status_type               stat_ff, stat_in;

   // Result register
   logic                     rsp_vld_ff, rsp_vld_in;
   status_type               rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_empty_ff;
   logic                     rsp_full_ff;
   logic signed [DATA_W-1:0] rsp_rval_ff;

   logic                     full;
   logic                     pos_lt;
   logic [AW-1:0]            pos_addr;
   logic [AW-1:0]            last_addr;
   logic [CW-1:0]            cnt_m1;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   status_type               err;

   // Checks on the captured command
   always_comb begin
      cnt_m1    = cnt_ff - CW'(1);
      full      = (cnt_ff == CW'(DEPTH));
      pos_lt    = (CMPW'(pos_ff) < CMPW'(cnt_ff));
      pos_addr  = AW'(pos_ff);
      last_addr = AW'(cnt_m1);
      unique case (op_ff)
         CMD_APPEND: err = full ? ST_FULL : ST_OK;
         CMD_INSERT: err = full ? ST_FULL : (pos_lt ? ST_OK : ST_RANGE);
         default:    err = pos_lt ? ST_OK : ST_RANGE;
      endcase
   end

   assign stat.op       = op_ff;
   assign stat.err      = err;
   assign stat.del_last = (CMPW'(pos_ff) == CMPW'(cnt_m1));
   assign stat.at_end   = (op_ff == CMD_INSERT) ? (src_ff == pos_addr) : (src_ff == last_addr);
   assign stat.out_free = !rsp_vld_ff || rsp_tready;

   // Memory address and data selection
   always_comb begin
      rd_addr = (ctrl.rd_sel == RD_POS) ? pos_addr : src_ff;
      unique case (ctrl.wr_sel)
         WR_APPEND: begin
            wr_addr = AW'(cnt_ff);
            wr_data = item_ff;
         end
         WR_INSERT: begin
            wr_addr = pos_addr;
            wr_data = item_ff;
         end
         default: begin
            wr_addr = wdst_ff;
            wr_data = rdata_ff;
         end
      endcase
   end

   // One write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
   end

   // Next values of pointers, count and status
   always_comb begin
      src_in  = src_ff;
      wdst_in = wdst_ff;
      if (ctrl.src_load) begin
         src_in = (op_ff == CMD_INSERT) ? last_addr : pos_addr + AW'(1);
      end else if (ctrl.src_step) begin
         src_in  = (op_ff == CMD_INSERT) ? src_ff - AW'(1) : src_ff + AW'(1);
         wdst_in = (op_ff == CMD_INSERT) ? src_ff + AW'(1) : src_ff - AW'(1);
      end

      cnt_in = cnt_ff;
      if (ctrl.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (ctrl.cnt_dec) begin
         cnt_in = cnt_m1;
      end

      stat_in = ctrl.stat_load ? err : stat_ff;

      rsp_vld_in = rsp_vld_ff;
      if (ctrl.res_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      wdst_ff <= wdst_in;
      stat_ff <= stat_in;
      if (ctrl.capture) begin
         op_ff   <= req_command;
         pos_ff  <= req_position;
         item_ff <= req_item;
      end
      if (ctrl.res_load) begin
         rsp_status_ff <= stat_ff;
         rsp_count_ff  <= COUNT_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
         rsp_full_ff   <= full;
         rsp_rval_ff   <= (op_ff == CMD_READ && stat_ff == ST_OK) ? rdata_ff : '0;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_flag = rsp_empty_ff;
   assign rsp_full_flag  = rsp_full_ff;
   assign rsp_read_value = rsp_rval_ff;

   // Count stays within the table
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // A failing command leaves the count alone
   a_err_keeps_cnt: assert property (@(posedge clock) disable iff (reset)
      (ctrl.stat_load && err != ST_OK) |=> $stable(cnt_ff))
      else $error("count changed on failing command");

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.res_load |-> (!rsp_vld_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

// ===== rtl/core/olid_ctrl.sv =====
module olid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  olid_pkg::dp_status_type stat,
   output olid_pkg::ctrl_type      ctrl
);
   import olid_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      ctrl        = '0;
      ctrl.rd_sel = RD_SRC;
      ctrl.wr_sel = WR_SHIFT;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            ctrl.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ctrl.stat_load = 1'b1;
            state_in       = S_FINISH;
            if (stat.err == ST_OK) begin
               unique case (stat.op)
                  CMD_APPEND: begin
                     ctrl.wr_en   = 1'b1;
                     ctrl.wr_sel  = WR_APPEND;
                     ctrl.cnt_inc = 1'b1;
                  end
                  CMD_READ: begin
                     ctrl.rd_en  = 1'b1;
                     ctrl.rd_sel = RD_POS;
                  end
                  CMD_INSERT: begin
                     ctrl.src_load = 1'b1;
                     state_in      = S_SHIFT0;
                  end
                  default: begin
                     if (stat.del_last) begin
                        ctrl.cnt_dec = 1'b1;
                     end else begin
                        ctrl.src_load = 1'b1;
                        state_in      = S_SHIFT0;
                     end
                  end
               endcase
            end
         end
         // First read of the move; nothing to write yet
         S_SHIFT0: begin
            ctrl.rd_en    = 1'b1;
            ctrl.src_step = 1'b1;
            state_in      = stat.at_end ? S_DRAIN : S_SHIFT;
         end
         // Read next source while writing the previous one
         S_SHIFT: begin
            ctrl.rd_en    = 1'b1;
            ctrl.src_step = 1'b1;
            ctrl.wr_en    = 1'b1;
            if (stat.at_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            ctrl.wr_en = 1'b1;
            if (stat.op == CMD_INSERT) begin
               state_in = S_INS_WR;
            end else begin
               ctrl.cnt_dec = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_INS_WR: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_sel  = WR_INSERT;
            ctrl.cnt_inc = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               ctrl.res_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // An accepted transaction is evaluated in the next cycle
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EVAL))
      else $error("accepted transaction not evaluated");

   // No memory write while idle or delivering
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FINISH) |-> !ctrl.wr_en)
      else $error("memory write outside a command");

   // Only insert and delete move entries
   a_shift_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT0) |-> (stat.op == CMD_INSERT || stat.op == CMD_DELETE))
      else $error("entry move for append or read");

endmodule

// ===== rtl/core/ordered_list_insert_delete_top.sv =====
// Ordered list of up to DEPTH signed 32-bit entries held in a single-port-write,
// registered-read memory. Each request transaction gives exactly one response
// transaction. Append, read, failing commands and a delete of the last entry move
// no entries. Insert moves count - position entries and delete count - 1 - position
// entries; the move copies one entry per cycle through the memory's one read and
// one write port. A waiting response does not block the next request; a new
// response waits only while the previous one is still held. The list is empty
// after reset, with no clearing pass.
module ordered_list_insert_delete_top #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command [1:0], position [5:2], item [37:6], zero fill above
   input  logic [olid_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [1:0], count [6:2], empty_flag [7], full_flag [8], read_value [40:9],
   // zero fill above
   output logic [olid_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import olid_pkg::*;

   localparam int RSP_PAD = RSP_TDATA_W - RSP_FIELD_W;

   ctrl_type                 ctrl;
   dp_status_type            stat;
   cmd_type                  req_command;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_item;
   status_type               rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_empty_flag;
   logic                     rsp_full_flag;
   logic signed [DATA_W-1:0] rsp_read_value;

   // Unpack request fields
   assign req_command  = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_position = req_tdata[CMD_W +: POS_W];
   assign req_item     = req_tdata[CMD_W + POS_W +: DATA_W];

   olid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   olid_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_item       (req_item),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_empty_flag (rsp_empty_flag),
      .rsp_full_flag  (rsp_full_flag),
      .rsp_read_value (rsp_read_value)
   );

   // Pack response fields
   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_read_value, rsp_full_flag, rsp_empty_flag,
                       rsp_count, rsp_status};

endmodule
